[hdl/kvt_pkg.sv]
// kvt_pkg: shared constants, codes and control types of the key-value table
`timescale 1ns / 1ps

package kvt_pkg;

  // default number of table slots
  localparam int TableDepth = 16;

  // fixed field widths
  localparam int ModeW   = 2;
  localparam int KeyW    = 32;
  localparam int ValW    = 32;
  localparam int StatusW = 2;
  localparam int CountW  = 5;

  // request codes
  typedef enum logic [ModeW-1:0] {
    MODE_LOOKUP = 2'd0,
    MODE_PUT    = 2'd1,
    MODE_ERASE  = 2'd2
  } mode_e;

  // result status codes
  typedef enum logic [StatusW-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_NOT_FOUND = 2'd1,
    STATUS_FULL      = 2'd2
  } status_e;

  // controller to datapath commands
  typedef struct packed {
    logic load;    // capture the request word and restart the scan
    logic scan;    // step the slot scan
    logic commit;  // apply the update and register the result
  } ctrl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic scan_done;  // key found or last slot compared
  } ctrl_stat_t;

endpackage

[hdl/key_value_table_unit.sv]
// key_value_table_unit: top level of the linearly searched key-value table
`timescale 1ns / 1ps
//
//  channel  | handshake        | words
//  ---------+------------------+----------------------------------------
//  request  | start, busy      | mode_i, key_i, value_in_i
//  result   | done_o (strobe)  | status_o, value_out_o, entry_count_o
//
//  a request word is taken on a clock edge with start high and busy low
//  the scan reads one slot per cycle from the key and value rams, so the result
//  strobe comes sooner when the key is found in a low slot
//  busy falls with the result strobe, so the next request word waits for that strobe
//  reset clears the slot-in-use flags and the entry count at once, no clearing pass
//  the result is shown for one cycle only; the receiver cannot stall it

module key_value_table_unit #(
  parameter int TABLE_DEPTH = kvt_pkg::TableDepth
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic [kvt_pkg::ModeW-1:0]         mode_i,
  input  logic signed [kvt_pkg::KeyW-1:0]   key_i,
  input  logic signed [kvt_pkg::ValW-1:0]   value_in_i,
  output logic                              done_o,
  output logic [kvt_pkg::StatusW-1:0]       status_o,
  output logic signed [kvt_pkg::ValW-1:0]   value_out_o,
  output logic [kvt_pkg::CountW-1:0]        entry_count_o
);

  kvt_pkg::ctrl_cmd_t  cmd;
  kvt_pkg::ctrl_stat_t stat;

  // sequencer
  kvt_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .cmd_o  (cmd),
    .stat_i (stat)
  );

  // slot store and scan
  kvt_datapath #(.TABLE_DEPTH(TABLE_DEPTH)) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .mode_i        (mode_i),
    .key_i         (key_i),
    .value_in_i    (value_in_i),
    .status_o      (status_o),
    .value_out_o   (value_out_o),
    .entry_count_o (entry_count_o)
  );

endmodule

[hdl/kvt_ram.sv]
// kvt_ram: generic single write port, single read port ram with registered read
`timescale 1ns / 1ps

module kvt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/kvt_ctrl.sv]
// kvt_ctrl: request sequencer of the key-value table
`timescale 1ns / 1ps

module kvt_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  output logic                done_o,
  output kvt_pkg::ctrl_cmd_t  cmd_o,
  input  kvt_pkg::ctrl_stat_t stat_i
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT
  } state_e;

  state_e state_q;
  logic   busy_q;
  logic   done_q;

  // commands follow the state
  always_comb begin
    cmd_o        = '0;
    cmd_o.load   = (state_q == ST_IDLE) && start;
    cmd_o.scan   = (state_q == ST_SCAN);
    cmd_o.commit = (state_q == ST_COMMIT);
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (start) begin
            state_q <= ST_SCAN;
            busy_q  <= 1'b1;
          end
        end
        ST_SCAN: begin
          if (stat_i.scan_done) begin
            state_q <= ST_COMMIT;
          end
        end
        ST_COMMIT: begin
          state_q <= ST_IDLE;
          busy_q  <= 1'b0;
          done_q  <= 1'b1;
        end
        default: begin
          state_q <= ST_IDLE;
          busy_q  <= 1'b0;
        end
      endcase
    end
  end

  assign busy   = busy_q;
  assign done_o = done_q;

`ifndef SYNTHESIS
  // busy tracks the state exactly
  a_busy_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q == (state_q != ST_IDLE))
    else $error("busy out of step with state");

  // an accepted word always starts a scan
  a_accept_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy_q) |=> (busy_q && state_q == ST_SCAN))
    else $error("accepted word did not start a scan");

  // the result strobe is a single pulse
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("result strobe held for more than a cycle");
`endif

endmodule

[hdl/kvt_datapath.sv]
// kvt_datapath: slot store, linear key scan and update logic of the key-value table
`timescale 1ns / 1ps

module kvt_datapath #(
  parameter int TABLE_DEPTH = kvt_pkg::TableDepth
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  kvt_pkg::ctrl_cmd_t                cmd_i,
  output kvt_pkg::ctrl_stat_t               stat_o,
  input  logic [kvt_pkg::ModeW-1:0]         mode_i,
  input  logic signed [kvt_pkg::KeyW-1:0]   key_i,
  input  logic signed [kvt_pkg::ValW-1:0]   value_in_i,
  output logic [kvt_pkg::StatusW-1:0]       status_o,
  output logic signed [kvt_pkg::ValW-1:0]   value_out_o,
  output logic [kvt_pkg::CountW-1:0]        entry_count_o
);

  localparam int IW   = $clog2(TABLE_DEPTH);
  localparam int CW   = $clog2(TABLE_DEPTH + 1);
  localparam int Last = TABLE_DEPTH - 1;

  // request word
  logic [kvt_pkg::ModeW-1:0] mode_q;
  logic [kvt_pkg::KeyW-1:0]  key_q;
  logic [kvt_pkg::ValW-1:0]  val_q;

  // slot state
  logic [TABLE_DEPTH-1:0] valid_q;
  logic [CW-1:0]          count_q;

  // scan pipeline: read issue stage and compare stage
  logic          issue_more_q;
  logic [IW-1:0] issue_idx_q;
  logic          cmp_vld_q;
  logic [IW-1:0] cmp_idx_q;

  // scan findings
  logic                     hit_q;
  logic [IW-1:0]            hit_idx_q;
  logic [kvt_pkg::ValW-1:0] hit_val_q;
  logic                     free_q;
  logic [IW-1:0]            free_idx_q;

  // result registers
  logic [kvt_pkg::StatusW-1:0] status_q;
  logic [kvt_pkg::ValW-1:0]    vout_q;

  // ram ports
  logic [kvt_pkg::KeyW-1:0] key_rdata;
  logic [kvt_pkg::ValW-1:0] val_rdata;
  logic                     key_we;
  logic                     val_we;
  logic [IW-1:0]            wr_idx;

  logic match;
  logic last_cmp;

  // key and value stores
  kvt_ram #(.WIDTH(kvt_pkg::KeyW), .DEPTH(TABLE_DEPTH)) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (wr_idx),
    .wdata_i (key_q),
    .raddr_i (issue_idx_q),
    .rdata_o (key_rdata)
  );

  kvt_ram #(.WIDTH(kvt_pkg::ValW), .DEPTH(TABLE_DEPTH)) u_val_ram (
    .clk_i   (clk_i),
    .we_i    (val_we),
    .waddr_i (wr_idx),
    .wdata_i (val_q),
    .raddr_i (issue_idx_q),
    .rdata_o (val_rdata)
  );

  // compare of the slot read back this cycle
  assign match    = cmp_vld_q && valid_q[cmp_idx_q] && (key_rdata == key_q);
  assign last_cmp = cmp_vld_q && (cmp_idx_q == IW'(Last));

  always_comb begin
    stat_o           = '0;
    stat_o.scan_done = match || last_cmp;
  end

  // commit write strobes: replace in place on a hit, new slot on a miss if one is free
  always_comb begin
    key_we = 1'b0;
    val_we = 1'b0;
    wr_idx = hit_q ? hit_idx_q : free_idx_q;
    if (cmd_i.commit && (mode_q == kvt_pkg::MODE_PUT)) begin
      val_we = hit_q || free_q;
      key_we = !hit_q && free_q;
    end
  end

  // request word capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q <= mode_i;
      key_q  <= key_i;
      val_q  <= value_in_i;
    end
  end

  // scan control and slot state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q      <= '0;
      count_q      <= '0;
      issue_more_q <= 1'b0;
      issue_idx_q  <= '0;
      cmp_vld_q    <= 1'b0;
      cmp_idx_q    <= '0;
      hit_q        <= 1'b0;
      free_q       <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        issue_more_q <= 1'b1;
        issue_idx_q  <= '0;
        cmp_vld_q    <= 1'b0;
        hit_q        <= 1'b0;
        free_q       <= 1'b0;
      end else if (cmd_i.scan) begin
        // issue one slot read per cycle
        cmp_vld_q <= issue_more_q;
        cmp_idx_q <= issue_idx_q;
        if (issue_more_q) begin
          if (issue_idx_q == IW'(Last)) begin
            issue_more_q <= 1'b0;
          end else begin
            issue_idx_q <= issue_idx_q + IW'(1);
          end
        end
        // record first match and first free slot
        if (match && !hit_q) begin
          hit_q <= 1'b1;
        end
        if (cmp_vld_q && !valid_q[cmp_idx_q] && !free_q) begin
          free_q <= 1'b1;
        end
      end else if (cmd_i.commit) begin
        if ((mode_q == kvt_pkg::MODE_PUT) && !hit_q && free_q) begin
          valid_q[free_idx_q] <= 1'b1;
          count_q             <= count_q + CW'(1);
        end else if ((mode_q == kvt_pkg::MODE_ERASE) && hit_q) begin
          valid_q[hit_idx_q] <= 1'b0;
          count_q            <= count_q - CW'(1);
        end
      end
    end
  end

  // scan finding payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.scan) begin
      if (match && !hit_q) begin
        hit_idx_q <= cmp_idx_q;
        hit_val_q <= val_rdata;
      end
      if (cmp_vld_q && !valid_q[cmp_idx_q] && !free_q) begin
        free_idx_q <= cmp_idx_q;
      end
    end
  end

  // result word
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      vout_q <= '0;
      unique case (mode_q)
        kvt_pkg::MODE_LOOKUP: begin
          status_q <= hit_q ? kvt_pkg::STATUS_OK : kvt_pkg::STATUS_NOT_FOUND;
          if (hit_q) begin
            vout_q <= hit_val_q;
          end
        end
        kvt_pkg::MODE_PUT: begin
          status_q <= (hit_q || free_q) ? kvt_pkg::STATUS_OK : kvt_pkg::STATUS_FULL;
        end
        kvt_pkg::MODE_ERASE: begin
          status_q <= hit_q ? kvt_pkg::STATUS_OK : kvt_pkg::STATUS_NOT_FOUND;
        end
        default: begin
          status_q <= kvt_pkg::STATUS_OK;
        end
      endcase
    end
  end

  assign status_o      = status_q;
  assign value_out_o   = vout_q;
  assign entry_count_o = kvt_pkg::CountW'(count_q);

`ifndef SYNTHESIS
  // entry count always equals the number of slots in use
  a_count_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) == int'(count_q))
    else $error("entry count differs from slots in use");

  // a committed put that neither hit nor found room leaves the table untouched
  a_full_no_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && !hit_q && !free_q) |=> $stable(valid_q))
    else $error("table changed on a missed request with no free slot");

  // a free slot is only missing when every slot is in use
  a_full_means_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && !hit_q && !free_q) |-> (valid_q == {TABLE_DEPTH{1'b1}}))
    else $error("no free slot found in a table with room");
`endif

endmodule

[dv/testbench.sv]
// testbench: self-checking test of the key-value table unit against its own table predictor
`timescale 1ns / 1ps

module testbench;
  import kvt_pkg::*;

  localparam int Depth = TableDepth;
  // no-operation request code, not part of the package enum
  localparam logic [ModeW-1:0] MODE_NOP = 2'd3;

  typedef struct {
    logic [StatusW-1:0] status;
    logic [ValW-1:0]    value;
    logic [CountW-1:0]  count;
  } kv_result_t;

  typedef struct {
    logic [ModeW-1:0] mode;
    logic [KeyW-1:0]  key;
    logic [ValW-1:0]  value;
    bit               typed;
    kv_result_t       want;
  } kv_row_t;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      start;
  logic                      busy;
  logic [ModeW-1:0]          mode_i;
  logic signed [KeyW-1:0]    key_i;
  logic signed [ValW-1:0]    value_in_i;
  logic                      done_o;
  logic [StatusW-1:0]        status_o;
  logic signed [ValW-1:0]    value_out_o;
  logic [CountW-1:0]         entry_count_o;

  // shadow copy of the table
  bit                        kv_used [Depth];
  logic [KeyW-1:0]           kv_key [Depth];
  logic [ValW-1:0]           kv_val [Depth];
  int                        kv_count;

  kv_result_t                pending_results[$];
  kv_row_t                   directed[$];

  // typed expectation for the word currently offered
  bit                        offer_typed;
  kv_result_t                offer_want;

  int                        error_count;
  int                        n_checked;
  int                        n_hits;
  int                        n_full;
  int                        n_erased;
  int                        n_replaced;
  int                        peak_count;

  key_value_table_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .mode_i        (mode_i),
    .key_i         (key_i),
    .value_in_i    (value_in_i),
    .done_o        (done_o),
    .status_o      (status_o),
    .value_out_o   (value_out_o),
    .entry_count_o (entry_count_o)
  );

  // clock
  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // apply one request to the shadow table and work out its result
  function automatic kv_result_t table_predict(input logic [ModeW-1:0] mode,
                                               input logic [KeyW-1:0] key,
                                               input logic [ValW-1:0] value);
    kv_result_t res;
    int         hit;
    int         free_idx;
    hit      = -1;
    free_idx = -1;
    for (int i = 0; i < Depth; i++) begin
      if (hit < 0 && kv_used[i] && kv_key[i] == key) hit = i;
      if (free_idx < 0 && !kv_used[i]) free_idx = i;
    end
    res.status = STATUS_OK;
    res.value  = '0;
    case (mode)
      MODE_LOOKUP: begin
        if (hit >= 0) begin
          res.value = kv_val[hit];
          n_hits++;
        end else begin
          res.status = STATUS_NOT_FOUND;
        end
      end
      MODE_PUT: begin
        if (hit >= 0) begin
          kv_val[hit] = value;
          n_replaced++;
        end else if (free_idx >= 0) begin
          kv_used[free_idx] = 1'b1;
          kv_key[free_idx]  = key;
          kv_val[free_idx]  = value;
          kv_count++;
        end else begin
          res.status = STATUS_FULL;
          n_full++;
        end
      end
      MODE_ERASE: begin
        if (hit >= 0) begin
          kv_used[hit] = 1'b0;
          kv_count--;
          n_erased++;
        end else begin
          res.status = STATUS_NOT_FOUND;
        end
      end
      default: ;
    endcase
    if (kv_count > peak_count) peak_count = kv_count;
    res.count = kv_count[CountW-1:0];
    return res;
  endfunction

  // result check first, then capture of an accepted request word
  always @(posedge clk_i) begin
    kv_result_t want;
    kv_result_t predicted;
    if (rst_ni) begin
      if (done_o) begin
        if (pending_results.size() == 0) begin
          $error("result word with nothing expected: status %0d value %0h count %0d",
                 status_o, value_out_o, entry_count_o);
          error_count++;
        end else begin
          want = pending_results.pop_front();
          n_checked++;
          if (status_o !== want.status) begin
            $error("status expected %0d got %0d", want.status, status_o);
            error_count++;
          end
          if (value_out_o !== want.value) begin
            $error("value_out expected %0h got %0h", want.value, value_out_o);
            error_count++;
          end
          if (entry_count_o !== want.count) begin
            $error("entry_count expected %0d got %0d", want.count, entry_count_o);
            error_count++;
          end
        end
      end
      if (start && !busy) begin
        predicted = table_predict(mode_i, key_i, value_in_i);
        pending_results.push_back(offer_typed ? offer_want : predicted);
      end
    end
  end

  // offer one word and hold it until taken; leaves start high
  task automatic send_word(input logic [ModeW-1:0] mode, input logic [KeyW-1:0] key,
                           input logic [ValW-1:0] value);
    mode_i     = mode;
    key_i      = key;
    value_in_i = value;
    start      = 1'b1;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
  endtask

  // idle the request side for a number of cycles with junk on the fields
  task automatic idle_cycles(input int n);
    if (n > 0) begin
      start = 1'b0;
      repeat (n) begin
        mode_i     = ModeW'($urandom);
        key_i      = $urandom;
        value_in_i = $urandom;
        @(negedge clk_i);
      end
    end
  endtask

  // mostly back to back or short gaps, now and then a long one
  function automatic int pick_gap(input bit gaps_on);
    int r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  task automatic drain_results();
    while (pending_results.size() != 0) @(negedge clk_i);
  endtask

  task automatic add_row(input logic [ModeW-1:0] mode, input logic [KeyW-1:0] key,
                         input logic [ValW-1:0] value, input bit typed,
                         input logic [StatusW-1:0] st, input logic [ValW-1:0] vo,
                         input logic [CountW-1:0] cnt);
    kv_row_t row;
    row.mode        = mode;
    row.key         = key;
    row.value       = value;
    row.typed       = typed;
    row.want.status = st;
    row.want.value  = vo;
    row.want.count  = cnt;
    directed.push_back(row);
  endtask

  // stimulus
  initial begin
    logic [KeyW-1:0]  key_pool[$];
    logic [ModeW-1:0] mode;
    logic [KeyW-1:0]  key;
    int               put_pct;
    int               erase_pct;
    int               sent;
    int               phase_len;
    int               pool_size;
    int               r;
    bit               gaps_on;

    rst_ni      = 1'b0;
    start       = 1'b0;
    mode_i      = MODE_LOOKUP;
    key_i       = '0;
    value_in_i  = '0;
    offer_typed = 1'b0;
    offer_want  = '{default: '0};
    error_count = 0;
    n_checked   = 0;
    n_hits      = 0;
    n_full      = 0;
    n_erased    = 0;
    n_replaced  = 0;
    peak_count  = 0;
    kv_count    = 0;
    for (int i = 0; i < Depth; i++) begin
      kv_used[i] = 1'b0;
      kv_key[i]  = '0;
      kv_val[i]  = '0;
    end

    // empty table, extremes, replace, no-op code
    add_row(MODE_LOOKUP, 32'h0, 32'h0, 1, STATUS_NOT_FOUND, 32'h0, 5'd0);
    add_row(MODE_ERASE, 32'h0, 32'hFFFF_FFFF, 1, STATUS_NOT_FOUND, 32'h0, 5'd0);
    add_row(MODE_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, STATUS_OK, 32'h0, 5'd0);
    add_row(MODE_PUT, 32'h7FFF_FFFF, 32'h8000_0000, 1, STATUS_OK, 32'h0, 5'd1);
    add_row(MODE_PUT, 32'h8000_0000, 32'h7FFF_FFFF, 1, STATUS_OK, 32'h0, 5'd2);
    add_row(MODE_LOOKUP, 32'h7FFF_FFFF, 32'h0, 1, STATUS_OK, 32'h8000_0000, 5'd2);
    add_row(MODE_LOOKUP, 32'h8000_0000, 32'h0, 1, STATUS_OK, 32'h7FFF_FFFF, 5'd2);
    add_row(MODE_PUT, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1, STATUS_OK, 32'h0, 5'd2);
    add_row(MODE_LOOKUP, 32'h7FFF_FFFF, 32'h0, 1, STATUS_OK, 32'hFFFF_FFFF, 5'd2);
    add_row(MODE_NOP, 32'h0, 32'h0, 1, STATUS_OK, 32'h0, 5'd2);
    // fill the rest of the table with alternating patterns
    for (int i = 0; i < Depth - 2; i++) begin
      add_row(MODE_PUT, (i % 2) ? 32'hAAAA_0000 + i : 32'h5555_0000 + i,
              (i % 2) ? 32'h5555_5555 : 32'hAAAA_AAAA, 0, STATUS_OK, 32'h0, 5'd0);
    end
    // full table, then free a slot and miss on the freed key
    add_row(MODE_PUT, 32'hFFFF_FFFF, 32'h1234_5678, 1, STATUS_FULL, 32'h0,
            CountW'(Depth));
    add_row(MODE_ERASE, 32'h8000_0000, 32'h0, 1, STATUS_OK, 32'h0, CountW'(Depth - 1));
    add_row(MODE_LOOKUP, 32'h8000_0000, 32'h0, 1, STATUS_NOT_FOUND, 32'h0,
            CountW'(Depth - 1));

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed table
    foreach (directed[i]) begin
      offer_typed = directed[i].typed;
      offer_want  = directed[i].want;
      send_word(directed[i].mode, directed[i].key, directed[i].value);
      idle_cycles(pick_gap(i >= 12));
    end
    offer_typed = 1'b0;

    // the sender waits for every outstanding result
    idle_cycles(1);
    drain_results();

    // random phases: each has its own key pool and put/erase balance
    sent = 0;
    while (sent < 1000) begin
      pool_size = $urandom_range(3, 24);
      key_pool.delete();
      for (int i = 0; i < pool_size; i++) begin
        r = $urandom_range(0, 9);
        key_pool.push_back(r == 0 ? 32'h8000_0000 : r == 1 ? 32'h7FFF_FFFF :
                           r == 2 ? 32'h0 : r == 3 ? 32'hFFFF_FFFF : $urandom);
      end
      put_pct   = $urandom_range(20, 65);
      erase_pct = $urandom_range(10, 40);
      gaps_on   = ($urandom_range(0, 3) != 0);
      phase_len = $urandom_range(60, 160);
      for (int n = 0; n < phase_len; n++) begin
        r = $urandom_range(0, 99);
        if (r < 3) mode = MODE_NOP;
        else if (r < 3 + put_pct) mode = MODE_PUT;
        else if (r < 3 + put_pct + erase_pct) mode = MODE_ERASE;
        else mode = MODE_LOOKUP;
        key = ($urandom_range(0, 99) < 88) ? key_pool[$urandom_range(0, pool_size - 1)]
                                           : $urandom;
        send_word(mode, key, $urandom);
        if (mode != MODE_NOP) sent++;
        idle_cycles(pick_gap(gaps_on));
      end
      // now and then let the table settle before the next phase
      if ($urandom_range(0, 2) == 0) begin
        idle_cycles(1);
        drain_results();
      end
    end

    // wind down
    idle_cycles(1);
    drain_results();
    repeat (Depth + 8) @(negedge clk_i);
    if (pending_results.size() != 0) begin
      $error("%0d expected result words never arrived", pending_results.size());
      error_count++;
    end

    $display("tb: %0d result words checked, %0d directed, %0d random requests",
             n_checked, directed.size(), sent);
    $display("tb: %0d lookup hits, %0d replacements, %0d erasures, %0d full refusals, peak %0d",
             n_hits, n_replaced, n_erased, n_full, peak_count);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2ms;
    $display("tb: failure");
    $finish;
  end

endmodule
